// ===== src/sitda_pkg.sv =====
`default_nettype none

package sitda_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int CHAR_WIDTH  = 8;

	localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'd48;
	localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'd45;
	localparam logic [3:0]            RADIX_MAX  = 4'd9;

	typedef struct packed {
		logic start;
		logic shift;
	} dab_ctl_t;

endpackage

`default_nettype wire

// ===== src/sitda_dabble.sv =====
`default_nettype none

module sitda_dabble #(
	parameter int DATA_WIDTH = 64,
	parameter int NDIG       = 20
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  sitda_pkg::dab_ctl_t      ctl,
	input  wire  [DATA_WIDTH-1:0]    mag,
	output logic                     busy,
	output logic [3:0]               top_digit
);

	localparam int CW = $clog2(DATA_WIDTH + 1);
	localparam int BW = NDIG * 4;

	logic [CW-1:0]         cnt_q;
	logic [DATA_WIDTH-1:0] mag_q;
	logic [BW-1:0]         bcd_q;
	logic [BW-1:0]         adj;

	// add three to every digit of five or more before the shift
	always_comb begin
		logic [3:0] d;
		adj = '0;
		for (int i = 0; i < NDIG; i++) begin
			d = bcd_q[i*4 +: 4];
			adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= CW'(DATA_WIDTH);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mag_q <= mag;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bcd_q <= {adj[BW-2:0], mag_q[DATA_WIDTH-1]};
			mag_q <= {mag_q[DATA_WIDTH-2:0], 1'b0};
		end else if (ctl.shift) begin
			bcd_q <= {bcd_q[BW-5:0], 4'd0};
		end
	end

	assign busy      = (cnt_q != '0);
	assign top_digit = bcd_q[BW-1 -: 4];

endmodule

`default_nettype wire

// ===== src/signed_int_to_decimal_ascii.sv =====
// channel  | valid       | stall       | payload
// input    | item_valid  | item_stall  | value
// output   | text_valid  | text_stall  | character, last
//
// an input transfer starts a bit-serial double dabble conversion; then leading zero digits are skipped,
// the skip state is left, a minus sign is sent when the value is negative, each digit is sent in turn
// and the control returns to idle
// arst_n clears the control state and the output valid
// text_stall holds the current character; item_stall stays high until the last
// character of the previous number has moved into the output register
`default_nettype none

module signed_int_to_decimal_ascii #(
	parameter int DATA_WIDTH = 64
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   item_valid,
	output logic                                  item_stall,
	input  wire  [sitda_pkg::VALUE_WIDTH-1:0]     value,
	output logic                                  text_valid,
	input  wire                                   text_stall,
	output logic [sitda_pkg::CHAR_WIDTH-1:0]      character,
	output logic                                  last
);

	localparam int NDIG = ((DATA_WIDTH * 1233) >> 12) + 1;
	localparam int RW   = $clog2(NDIG + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SKIP = 3'd2;
	localparam logic [2:0] ST_SIGN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]                          state_q;
	logic                                neg_q;
	logic [RW-1:0]                       rem_q;
	logic                                text_valid_q;
	logic [sitda_pkg::CHAR_WIDTH-1:0]    character_q;
	logic                                last_q;

	sitda_pkg::dab_ctl_t                 ctl;
	logic [DATA_WIDTH-1:0]               raw;
	logic [DATA_WIDTH-1:0]               mag;
	logic                                busy;
	logic [3:0]                          top_digit;
	logic                                accept;
	logic                                out_free;
	logic                                load_sign;
	logic                                load_digit;

	assign raw      = value[DATA_WIDTH-1:0];
	assign mag      = raw[DATA_WIDTH-1] ? (~raw + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : raw;
	assign accept   = item_valid && !item_stall;
	assign out_free = !text_valid_q || !text_stall;

	assign item_stall = (state_q != ST_IDLE);
	assign load_sign  = (state_q == ST_SIGN) && out_free;
	assign load_digit = (state_q == ST_EMIT) && out_free;

	always_comb begin
		ctl.start = accept;
		ctl.shift = load_digit ||
			((state_q == ST_SKIP) && (top_digit == 4'd0) && (rem_q > RW'(1)));
	end

	sitda_dabble #(
		.DATA_WIDTH(DATA_WIDTH),
		.NDIG      (NDIG)
	) u_dabble (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.mag      (mag),
		.busy     (busy),
		.top_digit(top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			neg_q   <= 1'b0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q   <= raw[DATA_WIDTH-1];
						rem_q   <= RW'(NDIG);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (!busy) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (ctl.shift) begin
						rem_q <= rem_q - 1'b1;
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (load_sign) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_digit) begin
						rem_q <= rem_q - 1'b1;
						if (rem_q == RW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid_q <= 1'b0;
		end else if (load_sign || load_digit) begin
			text_valid_q <= 1'b1;
		end else if (!text_stall) begin
			text_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_sign) begin
			character_q <= sitda_pkg::CHAR_MINUS;
			last_q      <= 1'b0;
		end else if (load_digit) begin
			character_q <= sitda_pkg::CHAR_ZERO + {4'd0, top_digit};
			last_q      <= (rem_q == RW'(1));
		end
	end

	assign text_valid = text_valid_q;
	assign character  = character_q;
	assign last       = last_q;

	ap_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid_q |-> (character_q == sitda_pkg::CHAR_MINUS ||
			(character_q >= sitda_pkg::CHAR_ZERO &&
			 character_q <= sitda_pkg::CHAR_ZERO + {4'd0, sitda_pkg::RADIX_MAX})))
		else $error("character out of range");

	ap_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(text_valid_q && character_q == sitda_pkg::CHAR_MINUS) |-> !last_q)
		else $error("minus sign flagged last");

	ap_start_conv: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy && state_q == ST_CONV))
		else $error("conversion did not start");

	ap_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP || state_q == ST_SIGN || state_q == ST_EMIT) |-> (rem_q != '0))
		else $error("digit count ran out");

	ap_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (top_digit <= sitda_pkg::RADIX_MAX))
		else $error("invalid bcd digit");

endmodule

`default_nettype wire
